// File: rtl/mwo_pkg.sv
// Package for the multi-waveform oscillator: shared constants, item types,
// sequencer states and the quarter-wave sine table builder.
// No dependencies.
package mwo_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_IDX_W       = SINE_AW + 2;
    localparam int SINE_W           = 17;
    localparam int PH_W             = 24;
    localparam int MAX_HARMONICS    = 128;
    localparam int HARM_W           = 8;

    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [23:0] INV_TWO_PI_Q26 = 24'd10680707;
    localparam logic [23:0] TWO_PI_Q16     = 24'd411775;
    localparam logic [31:0] LFSR_TAPS      = 32'h80200003;
    localparam logic [7:0]  HARMONIC_LIMIT_RESET = 8'd50;

    typedef enum logic [2:0] {
        W_SINE     = 3'd0,
        W_SQUARE   = 3'd1,
        W_TRIANGLE = 3'd2,
        W_ADD_SAW  = 3'd3,
        W_DIG_SAW  = 3'd4,
        W_NOISE    = 3'd5,
        W_SILENCE  = 3'd6
    } t_wave;

    typedef struct packed {
        t_wave              wave;
        logic [31:0]        time_seconds;
        logic [21:0]        tone_hz;
        logic [15:0]        vibrato_hz;
        logic [15:0]        vibrato_depth;
        logic signed [16:0] noise;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TONE_MUL,
        ST_LFO_MUL,
        ST_DEP_MUL,
        ST_M_MUL,
        ST_TERM_MUL,
        ST_WAVE,
        ST_SINE_A,
        ST_SINE_B,
        ST_HARM_A,
        ST_HARM_B,
        ST_HARM_C,
        ST_HARM_DIV,
        ST_SAW_MUL,
        ST_OUT
    } t_state;

    typedef logic [SINE_W-1:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    // Q30 Taylor series through x^11, rounded to Q15 and clamped at one.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'(k) * HALF_PI_Q30) >> SINE_AW;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        r    = (sum + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[SINE_W-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            rom[i] = quarter_sine(i);
        end
        return rom;
    endfunction

endpackage

// File: rtl/mwo_if.sv
// Handshake channels of the oscillator: input item and output sample.
// No dependencies.
interface mwo_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] time_seconds;
    logic [21:0] tone_hz;
    logic [15:0] vibrato_hz;
    logic [15:0] vibrato_depth;
    modport source (output valid, cmd, time_seconds, tone_hz, vibrato_hz, vibrato_depth,
                    input ready);
    modport sink (input valid, cmd, time_seconds, tone_hz, vibrato_hz, vibrato_depth,
                  output ready);
endinterface

interface mwo_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] sample;
    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

// File: rtl/mwo_front.sv
// Front end: accepts input transactions, classifies the waveform and steps
// the noise LFSR in arrival order. Depends on mwo_pkg and mwo_if.
module mwo_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mwo_in_if.sink       i_in,
    input  logic         i_full,
    output logic         o_push,
    output mwo_pkg::t_job o_job
);
    import mwo_pkg::*;

    logic [31:0] r_lfsr;
    logic [31:0] n_lfsr;
    logic [31:0] lfsr_step;
    t_wave       wave;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        case (i_in.cmd)
            W_SINE:     wave = W_SINE;
            W_SQUARE:   wave = W_SQUARE;
            W_TRIANGLE: wave = W_TRIANGLE;
            W_ADD_SAW:  wave = W_ADD_SAW;
            W_DIG_SAW:  wave = W_DIG_SAW;
            W_NOISE:    wave = W_NOISE;
            default:    wave = W_SILENCE;
        endcase
    end

    always_comb begin
        lfsr_step = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);
        n_lfsr    = (o_push && wave == W_NOISE) ? lfsr_step : r_lfsr;
        o_job.wave          = wave;
        o_job.time_seconds  = i_in.time_seconds;
        o_job.tone_hz       = i_in.tone_hz;
        o_job.vibrato_hz    = i_in.vibrato_hz;
        o_job.vibrato_depth = i_in.vibrato_depth;
        o_job.noise         = $signed({1'b0, lfsr_step[31:16]} - 17'd32768);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= 32'd1;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

endmodule

// File: rtl/mwo_queue.sv
// Two-entry queue of classified jobs between the front end and the sequencer.
// Depends on mwo_pkg.
module mwo_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mwo_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output mwo_pkg::t_job o_job
);
    import mwo_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: rtl/mwo_back.sv
// Back end: sequencer that forms the vibrato phase with a shift-add multiplier,
// evaluates the waveform and holds the result. Depends on mwo_pkg and mwo_if.
module mwo_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mwo_pkg::t_job i_job,
    input  logic [7:0]    i_harmonic_limit,
    output logic          o_pop,
    mwo_out_if.source     o_out
);
    import mwo_pkg::*;

    localparam t_sine_rom SINE_ROM = build_sine_rom();
    localparam logic [SINE_AW:0] DEPTH_L = (SINE_AW + 1)'(SINE_TABLE_DEPTH);
    localparam logic [HARM_W:0]  MAX_L   = (HARM_W + 1)'(MAX_HARMONICS);

    t_state              r_state, n_state;
    t_job                r_job, n_job;
    logic [63:0]         r_ma, n_ma;
    logic [23:0]         r_mb, n_mb;
    logic [63:0]         r_prod, n_prod;
    logic [PH_W-1:0]     r_ph_tone, n_ph_tone;
    logic [PH_W-1:0]     r_ph, n_ph;
    logic [PH_W-1:0]     r_nph, n_nph;
    logic [SINE_AW:0]    r_rom_addr, n_rom_addr;
    logic [SINE_W-1:0]   r_rom_q;
    logic                r_sneg, n_sneg;
    logic [HARM_W-1:0]   r_n, n_n;
    logic [HARM_W-1:0]   r_lim, n_lim;
    logic signed [39:0]  r_acc, n_acc;
    logic [31:0]         r_div, n_div;
    logic [HARM_W-1:0]   r_rem, n_rem;
    logic [5:0]          r_cnt, n_cnt;
    logic signed [27:0]  r_val, n_val;
    logic                r_out_valid, n_out_valid;
    logic signed [19:0]  r_sample, n_sample;

    logic                mul_done;
    logic [45:0]         term_mag;
    logic [16:0]         tri_q;
    logic [15:0]         saw_q;
    logic [16:0]         saw_sum;
    logic [HARM_W:0]     lim_ext;
    logic [HARM_W:0]     rem2;
    logic [HARM_W:0]     n_inc;
    logic signed [39:0]  quot;
    logic signed [39:0]  acc_next;
    logic [39:0]         acc_abs;
    logic [63:0]         saw_round;

    function automatic logic [SINE_AW+1:0] sine_addr(input logic [PH_W-1:0] ph);
        logic [SINE_IDX_W-1:0] idx;
        logic [SINE_AW:0]      k;
        idx = ph[PH_W-1 -: SINE_IDX_W];
        k   = {1'b0, idx[SINE_AW-1:0]};
        return {idx[SINE_IDX_W-1], idx[SINE_AW] ? DEPTH_L - k : k};
    endfunction

    function automatic logic signed [19:0] saturate(input logic signed [27:0] v);
        if (v > 28'sd524287) begin
            return 20'sd524287;
        end else if (v < -28'sd524288) begin
            return -20'sd524288;
        end
        return v[19:0];
    endfunction

    assign mul_done    = (r_mb == 24'd0);
    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_sample;

    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE_ROM[r_rom_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_prod      = r_prod;
        n_ph_tone   = r_ph_tone;
        n_ph        = r_ph;
        n_nph       = r_nph;
        n_rom_addr  = r_rom_addr;
        n_sneg      = r_sneg;
        n_n         = r_n;
        n_lim       = r_lim;
        n_acc       = r_acc;
        n_div       = r_div;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_val       = r_val;
        n_sample    = r_sample;
        n_out_valid = r_out_valid && !o_out.ready;
        o_pop       = 1'b0;

        term_mag  = 46'((r_prod + 64'd16384) >> 15);
        tri_q     = r_ph[PH_W-1:7];
        saw_q     = r_ph[PH_W-1:8];
        saw_sum   = {1'b0, saw_q} + 17'd16384;
        lim_ext   = ({1'b0, i_harmonic_limit} > MAX_L) ? MAX_L : {1'b0, i_harmonic_limit};
        rem2      = {r_rem, r_div[31]};
        n_inc     = {1'b0, r_n} + 1'b1;
        quot      = $signed({8'd0, r_div});
        acc_next  = r_acc + (r_sneg ? -quot : quot);
        acc_abs   = acc_next[39] ? 40'(-acc_next) : 40'(acc_next);
        saw_round = (r_prod + 64'h8000_0000) >> 32;

        // Shared shift-add multiplier: one partial product per cycle.
        if (!mul_done) begin
            n_prod = r_prod + (r_mb[0] ? r_ma : 64'd0);
            n_ma   = r_ma << 1;
            n_mb   = r_mb >> 1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    case (i_job.wave)
                        W_NOISE: begin
                            n_val   = 28'(i_job.noise);
                            n_state = ST_OUT;
                        end
                        W_SILENCE: begin
                            n_val   = '0;
                            n_state = ST_OUT;
                        end
                        default: begin
                            n_ma    = {32'd0, i_job.time_seconds};
                            n_mb    = {2'd0, i_job.tone_hz};
                            n_prod  = '0;
                            n_state = ST_TONE_MUL;
                        end
                    endcase
                end
            end
            ST_TONE_MUL: begin
                if (mul_done) begin
                    n_ph_tone = r_prod[PH_W-1:0];
                    n_ma      = {32'd0, r_job.time_seconds};
                    n_mb      = {8'd0, r_job.vibrato_hz};
                    n_prod    = '0;
                    n_state   = ST_LFO_MUL;
                end
            end
            ST_LFO_MUL: begin
                if (mul_done) begin
                    {n_sneg, n_rom_addr} = sine_addr(r_prod[PH_W-1:0]);
                    n_ma    = {48'd0, r_job.vibrato_depth};
                    n_mb    = {2'd0, r_job.tone_hz};
                    n_prod  = '0;
                    n_state = ST_DEP_MUL;
                end
            end
            ST_DEP_MUL: begin
                if (mul_done) begin
                    n_ma    = r_prod;
                    n_mb    = INV_TWO_PI_Q26;
                    n_prod  = '0;
                    n_state = ST_M_MUL;
                end
            end
            ST_M_MUL: begin
                // The LFO sine read was issued on leaving ST_LFO_MUL, so the registered table output is settled.
                if (mul_done) begin
                    n_ma    = {18'd0, r_prod[63:18]};
                    n_mb    = {7'd0, r_rom_q};
                    n_prod  = '0;
                    n_state = ST_TERM_MUL;
                end
            end
            ST_TERM_MUL: begin
                if (mul_done) begin
                    n_ph    = r_sneg ? r_ph_tone - term_mag[PH_W-1:0]
                                     : r_ph_tone + term_mag[PH_W-1:0];
                    n_state = ST_WAVE;
                end
            end
            ST_WAVE: begin
                case (r_job.wave)
                    W_SINE: begin
                        {n_sneg, n_rom_addr} = sine_addr(r_ph);
                        n_state = ST_SINE_A;
                    end
                    W_SQUARE: begin
                        n_val   = (r_ph != '0 && !r_ph[PH_W-1]) ? 28'sd32768 : -28'sd32768;
                        n_state = ST_OUT;
                    end
                    W_TRIANGLE: begin
                        if (tri_q <= 17'd32768) begin
                            n_val = $signed({11'd0, tri_q});
                        end else if (tri_q <= 17'd98304) begin
                            n_val = 28'sd65536 - $signed({11'd0, tri_q});
                        end else begin
                            n_val = $signed({11'd0, tri_q}) - 28'sd131072;
                        end
                        n_state = ST_OUT;
                    end
                    W_DIG_SAW: begin
                        n_val   = $signed({11'd0, saw_q, 1'b0})
                                - $signed({10'd0, saw_sum[16:15], 16'd0});
                        n_state = ST_OUT;
                    end
                    W_ADD_SAW: begin
                        if (lim_ext <= 9'd1) begin
                            n_val   = '0;
                            n_state = ST_OUT;
                        end else begin
                            n_lim   = lim_ext[HARM_W-1:0];
                            n_n     = HARM_W'(1);
                            n_nph   = r_ph;
                            n_acc   = '0;
                            n_state = ST_HARM_A;
                        end
                    end
                    default: begin
                        n_val   = '0;
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_SINE_A: begin
                n_state = ST_SINE_B;
            end
            ST_SINE_B: begin
                n_val   = r_sneg ? -$signed({11'd0, r_rom_q}) : $signed({11'd0, r_rom_q});
                n_state = ST_OUT;
            end
            ST_HARM_A: begin
                {n_sneg, n_rom_addr} = sine_addr(r_nph);
                n_state = ST_HARM_B;
            end
            ST_HARM_B: begin
                n_state = ST_HARM_C;
            end
            ST_HARM_C: begin
                // The table never exceeds 2^15, so the shifted value fits 32 bits.
                n_div   = {r_rom_q[15:0], 16'd0};
                n_rem   = '0;
                n_cnt   = 6'd32;
                n_state = ST_HARM_DIV;
            end
            ST_HARM_DIV: begin
                if (r_cnt != 6'd0) begin
                    if (rem2 >= {1'b0, r_n}) begin
                        n_rem = HARM_W'(rem2 - {1'b0, r_n});
                        n_div = {r_div[30:0], 1'b1};
                    end else begin
                        n_rem = rem2[HARM_W-1:0];
                        n_div = {r_div[30:0], 1'b0};
                    end
                    n_cnt = r_cnt - 6'd1;
                end else begin
                    n_acc = acc_next;
                    n_n   = n_inc[HARM_W-1:0];
                    n_nph = r_nph + r_ph;
                    if (n_inc == {1'b0, r_lim}) begin
                        n_ma    = {24'd0, acc_abs};
                        n_mb    = TWO_PI_Q16;
                        n_prod  = '0;
                        n_state = ST_SAW_MUL;
                    end else begin
                        n_state = ST_HARM_A;
                    end
                end
            end
            ST_SAW_MUL: begin
                if (mul_done) begin
                    n_val   = r_acc[39] ? -$signed({1'b0, saw_round[26:0]})
                                        : $signed({1'b0, saw_round[26:0]});
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_sample    = saturate(r_val);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_ma       <= n_ma;
        r_mb       <= n_mb;
        r_prod     <= n_prod;
        r_ph_tone  <= n_ph_tone;
        r_ph       <= n_ph;
        r_nph      <= n_nph;
        r_rom_addr <= n_rom_addr;
        r_sneg     <= n_sneg;
        r_n        <= n_n;
        r_lim      <= n_lim;
        r_acc      <= n_acc;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_val      <= n_val;
        r_sample   <= n_sample;
    end

endmodule

// File: rtl/multi_waveform_oscillator_unit.sv
// Flow: noise and silence go from the queue straight to the output state;
// other waveforms add the serial phase multiplies (one multiplier bit per cycle),
// and the additive saw adds a table read and the 32-step divider per harmonic.
// One item is worked at a time; a two-entry queue and the output register take
// items while a result waits. Reset (synchronous, active low) empties the queue,
// sets the LFSR to one and the harmonic limit to 50.
module multi_waveform_oscillator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mwo_in_if.sink     i_in,
    mwo_out_if.source  o_out
);
    import mwo_pkg::*;

    logic [7:0] r_harmonic_limit;
    logic       push;
    logic       full;
    logic       q_valid;
    logic       pop;
    t_job       front_job;
    t_job       q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harmonic_limit <= HARMONIC_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_harmonic_limit <= i_cfg_wdata;
        end
    end

    mwo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    mwo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    mwo_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_job            (q_job),
        .i_harmonic_limit (r_harmonic_limit),
        .o_pop            (pop),
        .o_out            (o_out)
    );

endmodule

// File: rtl/mwo_checker.sv
// Port-level checker for the oscillator, bound to the top level.
// Depends on multi_waveform_oscillator_unit and mwo_if.
module mwo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [19:0] i_out_sample
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample))
        else $error("output sample changed while stalled");

    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind multi_waveform_oscillator_unit mwo_checker u_mwo_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample)
);

// File: verif/mwo_checker.sv
// Scoreboard for the multi-waveform oscillator: watches the input, output and
// register write ports, predicts each sample and compares it in order.
// Depends on mwo_pkg and the mwo_in_if / mwo_out_if interfaces.
module mwo_scoreboard (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mwo_in_if          in_ch,
    mwo_out_if         out_ch,
    output int         o_errors,
    output int         o_pending
);
    import mwo_pkg::*;

    logic [16:0]        quarter_tbl [0:SINE_TABLE_DEPTH];
    logic signed [19:0] sample_queue [$];
    logic [7:0]         harm_limit;
    logic [31:0]        lfsr;

    function automatic logic [16:0] taylor_quarter(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int i = 1; i <= 5; i++) begin
            term = ((term * x2) >> 30) / ((2 * i) * (2 * i + 1));
            if (i % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[16:0];
    endfunction

    function automatic longint sine_q15(input logic [23:0] ph);
        longint unsigned idx;
        int unsigned     quad;
        int unsigned     k;
        longint          v;
        idx  = (longint'(ph) * (4 * SINE_TABLE_DEPTH)) >> 24;
        quad = idx / SINE_TABLE_DEPTH;
        k    = idx % SINE_TABLE_DEPTH;
        v    = (quad % 2 == 1) ? quarter_tbl[SINE_TABLE_DEPTH - k] : quarter_tbl[k];
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic longint round_off(input longint unsigned mag, input int sh,
                                         input bit neg);
        longint unsigned r;
        r = (mag + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Computes the expected sample; advances the noise register on noise items.
    function automatic logic signed [19:0] predict_sample(input logic [2:0] cmd,
        input logic [31:0] t, input logic [21:0] f, input logic [15:0] fl,
        input logic [15:0] dep);
        logic [23:0]     ph_tone;
        logic [23:0]     ph_lfo;
        logic [23:0]     ph;
        longint          s_lfo;
        longint unsigned m;
        longint          term;
        longint          v;
        longint          q;
        longint          acc;
        longint unsigned mag;
        int unsigned     lim;
        ph_tone = 24'(longint'(f) * longint'(t));
        ph_lfo  = 24'(longint'(fl) * longint'(t));
        s_lfo   = sine_q15(ph_lfo);
        m       = ((longint'(dep) * longint'(f)) * longint'(INV_TWO_PI_Q26)) >> 18;
        term    = round_off(m * ((s_lfo < 0) ? -s_lfo : s_lfo), 15, s_lfo < 0);
        ph      = 24'(longint'(ph_tone) + term);
        v       = 0;
        case (cmd)
            W_SINE: v = sine_q15(ph);
            W_SQUARE: v = (ph > 0 && ph < 24'h800000) ? 32768 : -32768;
            W_TRIANGLE: begin
                q = ph >> 7;
                if (q <= 32768) begin
                    v = q;
                end else if (q <= 98304) begin
                    v = 65536 - q;
                end else begin
                    v = q - 131072;
                end
            end
            W_ADD_SAW: begin
                lim = (harm_limit > MAX_HARMONICS) ? MAX_HARMONICS : harm_limit;
                acc = 0;
                for (int n = 1; n < lim; n++) begin
                    acc += (sine_q15(24'(longint'(ph) * n)) * 65536) / n;
                end
                mag = (acc < 0) ? -acc : acc;
                v   = round_off(mag * TWO_PI_Q16, 32, acc < 0);
            end
            W_DIG_SAW: begin
                q = ph >> 8;
                v = 2 * (q - ((q + 16384) / 32768) * 32768);
            end
            W_NOISE: begin
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                v    = longint'(lfsr >> 16) - 32768;
            end
            default: v = 0;
        endcase
        if (v > 524287) begin
            v = 524287;
        end
        if (v < -524288) begin
            v = -524288;
        end
        return v[19:0];
    endfunction

    initial begin
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            quarter_tbl[i] = taylor_quarter(i);
        end
    end

    always @(posedge i_clk) begin
        logic signed [19:0] want;
        if (!i_rst_n) begin
            harm_limit = HARMONIC_LIMIT_RESET;
            lfsr       = 32'd1;
            o_errors   = 0;
            sample_queue.delete();
        end else begin
            if (i_cfg_we) begin
                harm_limit = i_cfg_wdata;
            end
            // A sample can never belong to an item accepted at the same edge.
            if (out_ch.valid && out_ch.ready) begin
                if (sample_queue.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("unexpected sample %0d", out_ch.sample);
                    end
                end else begin
                    want = sample_queue.pop_front();
                    if (want !== out_ch.sample) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("sample mismatch: expected %0d, got %0d",
                                     want, out_ch.sample);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                sample_queue.push_back(predict_sample(in_ch.cmd, in_ch.time_seconds,
                    in_ch.tone_hz, in_ch.vibrato_hz, in_ch.vibrato_depth));
            end
        end
        o_pending = sample_queue.size();
    end

endmodule

// File: verif/tb.sv
// Top of the oscillator testbench: clock, reset, stimulus, receiver stalls and
// the verdict. Depends on mwo_pkg, the channel interfaces, mwo_scoreboard and the RTL.
module tb;
    import mwo_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   steady = 1'b0;

    mwo_in_if  in_ch ();
    mwo_out_if out_ch ();

    multi_waveform_oscillator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    mwo_scoreboard scoreboard (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.time_seconds = '0;
        in_ch.tone_hz = '0;
        in_ch.vibrato_hz = '0;
        in_ch.vibrato_depth = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off now and then so the
    // queue fills and the input stalls.
    always @(negedge i_clk) begin
        if (i_rst_n && cycles % 20000 == 3000) begin
            out_ch.ready <= 1'b0;
            repeat (400) @(negedge i_clk);
        end else begin
            out_ch.ready <= steady || ($urandom_range(99) >= 19);
        end
    end

    task automatic drive_item(input logic [2:0] cmd, input logic [31:0] t,
                              input logic [21:0] f, input logic [15:0] fl,
                              input logic [15:0] dep);
        if (!steady && $urandom_range(99) < 19) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(6)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.time_seconds <= t;
        in_ch.tone_hz <= f;
        in_ch.vibrato_hz <= fl;
        in_ch.vibrato_depth <= dep;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drive_random_item();
        logic [2:0] cmd;
        logic [15:0] fl;
        logic [15:0] dep;
        cmd = 3'($urandom_range(7));
        fl  = 16'($urandom());
        dep = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom());
        if ($urandom_range(3) == 0) begin
            fl = 16'($urandom_range(1024));
        end
        drive_item(cmd, $urandom(), 22'($urandom()), fl, dep);
    endtask

    task automatic write_limit(input logic [7:0] value);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0] limits [7];
        int         counts [7];
        limits = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd128, 8'd50, 8'd13};
        counts = '{250, 250, 230, 15, 15, 400, 270};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset harmonic limit: every waveform at the
        // extremes, silence codes, and noise repeated to walk the shift register.
        for (int c = 0; c < 8; c++) begin
            drive_item(3'(c), 32'hFFFF_FFFF, 22'h3F_FFFF, 16'hFFFF, 16'hFFFF);
        end
        for (int c = 0; c < 8; c++) begin
            drive_item(3'(c), 32'h0001_0000, 22'd110 << 8, 16'd0, 16'd0);
        end
        drive_item(W_SINE, '0, '0, '0, '0);
        drive_item(W_SQUARE, 32'h0000_8000, 22'h100, 16'h0600, 16'h0100);
        drive_item(W_NOISE, '0, '0, '0, '0);
        drive_item(W_NOISE, 32'h1234_5678, 22'h2A_AAAA, 16'h5555, 16'hAAAA);
        drive_item(W_NOISE, '0, '0, '0, '0);

        for (int p = 0; p < 7; p++) begin
            write_limit(limits[p]);
            for (int i = 0; i < counts[p]; i++) begin
                if (i % 100 == 40) begin
                    steady = 1'b1;
                end else if (i % 100 == 70) begin
                    steady = 1'b0;
                end
                drive_random_item();
            end
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: multi_waveform_oscillator_unit.f
rtl/mwo_pkg.sv
rtl/mwo_if.sv
rtl/mwo_front.sv
rtl/mwo_queue.sv
rtl/mwo_back.sv
rtl/multi_waveform_oscillator_unit.sv
rtl/mwo_checker.sv
verif/mwo_checker.sv
verif/tb.sv
